// ===== rtl/pidl_pkg.sv =====
`timescale 1ns / 1ps
package pidl_pkg;

    // Default sizes
    localparam int DEPTH_DEF     = 8;
    localparam int WORD_BITS_DEF = 32;

    // Fixed field widths
    localparam int OP_BITS     = 2;
    localparam int POS_BITS    = 4;
    localparam int VALUE_BITS  = 32;
    localparam int STATUS_BITS = 2;
    localparam int FILL_BITS   = 4;

    typedef enum logic [OP_BITS-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_EDIT   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_DONE   = 2'd0,
        ST_APPEND = 2'd1,
        ST_FULL   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    // What one cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_LOAD      = 2'd1,
        CELL_FROM_PREV = 2'd2,
        CELL_FROM_NEXT = 2'd3
    } t_cell_op;

    typedef struct packed {
        logic [OP_BITS-1:0]    operation;
        logic [POS_BITS-1:0]   position;
        logic [VALUE_BITS-1:0] value;
    } t_in;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic [FILL_BITS-1:0]   fill_count;
        logic                   list_full;
    } t_out;

endpackage

// ===== rtl/positional_insert_delete_list_core.sv =====
`timescale 1ns / 1ps
// Positional insert/delete list.
// Holds a packed list of up to DEPTH words in a row of cells plus a fill count.
// Input channel (i_in_valid / o_in_ready / i_in): one item carries an operation
// (insert, delete, edit), a 1-based position and a value.
// Output channel (o_out_valid / i_out_ready / o_out): one result per item with
// a status, the fill count after the operation and a full flag.
// The result is registered and appears in the cycle after the item is
// taken. One item is taken per cycle unless a stalled receiver holds the
// result; every cell loads or shifts from its neighbor in the same cycle.
// The input is ready whenever the result register is empty or being drained,
// so a stalled receiver holds the result and stops intake one item deep.
// Reset empties the list (fill count zero) and clears the result register;
// stored words have no reset and are never shown.
module positional_insert_delete_list_core #(
    parameter int DEPTH     = pidl_pkg::DEPTH_DEF,
    parameter int WORD_BITS = pidl_pkg::WORD_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  pidl_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pidl_pkg::t_out o_out
);

    logic                 w_fire;
    pidl_pkg::t_cell_op   w_cmd [DEPTH];
    pidl_pkg::t_out       w_result;
    logic [WORD_BITS-1:0] w_data [DEPTH];
    logic [WORD_BITS-1:0] w_load;
    logic                 r_out_valid;
    pidl_pkg::t_out       r_out;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_load     = WORD_BITS'(i_in.value);

    pidl_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_item   (i_in),
        .o_cmd    (w_cmd),
        .o_result (w_result)
    );

    // Row of cells, each linked to both neighbors
    for (genvar k = 0; k < DEPTH; k++) begin : g_cell
        logic [WORD_BITS-1:0] w_prev;
        logic [WORD_BITS-1:0] w_next;
        if (k == 0) begin : g_first
            assign w_prev = '0;
        end else begin : g_prev
            assign w_prev = w_data[k-1];
        end
        if (k == DEPTH - 1) begin : g_last
            assign w_next = '0;
        end else begin : g_next
            assign w_next = w_data[k+1];
        end
        pidl_cell #(
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_cmd  (w_cmd[k]),
            .i_load (w_load),
            .i_prev (w_prev),
            .i_next (w_next),
            .o_data (w_data[k])
        );
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/pidl_cell.sv =====
`timescale 1ns / 1ps
module pidl_cell #(
    parameter int WORD_BITS = pidl_pkg::WORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  pidl_pkg::t_cell_op   i_cmd,
    input  logic [WORD_BITS-1:0] i_load,
    input  logic [WORD_BITS-1:0] i_prev,
    input  logic [WORD_BITS-1:0] i_next,
    output logic [WORD_BITS-1:0] o_data
);

    logic [WORD_BITS-1:0] r_data;
    logic [WORD_BITS-1:0] n_data;

    // Pick the new word: keep, take the new item, or shift from a neighbor
    always_comb begin
        case (i_cmd)
            pidl_pkg::CELL_LOAD:      n_data = i_load;
            pidl_pkg::CELL_FROM_PREV: n_data = i_prev;
            pidl_pkg::CELL_FROM_NEXT: n_data = i_next;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ===== rtl/pidl_ctrl.sv =====
`timescale 1ns / 1ps
module pidl_ctrl #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  pidl_pkg::t_in      i_item,
    output pidl_pkg::t_cell_op o_cmd [DEPTH],
    output pidl_pkg::t_out     o_result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = ((CW > pidl_pkg::POS_BITS) ? CW : pidl_pkg::POS_BITS) + 1;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [EW-1:0] w_pos;
    logic [EW-1:0] w_cnt;
    logic [EW-1:0] w_depth;
    logic          w_pos_zero;
    pidl_pkg::t_status w_status;

    assign w_pos      = EW'(i_item.position);
    assign w_cnt      = EW'(r_count);
    assign w_depth    = EW'(DEPTH);
    assign w_pos_zero = (w_pos == '0);

    // Decode the operation into a status, the new count and one command per cell
    always_comb begin
        w_status = pidl_pkg::ST_RANGE;
        n_count  = r_count;
        for (int k = 0; k < DEPTH; k++) begin
            o_cmd[k] = pidl_pkg::CELL_HOLD;
        end
        unique case (pidl_pkg::t_op'(i_item.operation))
            pidl_pkg::OP_INSERT: begin
                if (w_cnt == w_depth) begin
                    w_status = pidl_pkg::ST_FULL;
                end else if (w_pos_zero || w_pos > w_depth) begin
                    w_status = pidl_pkg::ST_RANGE;
                end else if (w_pos > w_cnt + EW'(1)) begin
                    // append at the first free cell
                    w_status = pidl_pkg::ST_APPEND;
                    n_count  = CW'(w_cnt + EW'(1));
                    for (int k = 0; k < DEPTH; k++) begin
                        if (EW'(k) == w_cnt) o_cmd[k] = pidl_pkg::CELL_LOAD;
                    end
                end else begin
                    // load at the position, push later entries back
                    w_status = pidl_pkg::ST_DONE;
                    n_count  = CW'(w_cnt + EW'(1));
                    for (int k = 0; k < DEPTH; k++) begin
                        if (EW'(k) + EW'(1) == w_pos) begin
                            o_cmd[k] = pidl_pkg::CELL_LOAD;
                        end else if (EW'(k) + EW'(1) > w_pos) begin
                            o_cmd[k] = pidl_pkg::CELL_FROM_PREV;
                        end
                    end
                end
            end
            pidl_pkg::OP_DELETE: begin
                if (!(w_pos_zero || w_pos > w_cnt)) begin
                    // pull later entries forward over the removed one
                    w_status = pidl_pkg::ST_DONE;
                    n_count  = CW'(w_cnt - EW'(1));
                    for (int k = 0; k < DEPTH - 1; k++) begin
                        if (EW'(k) + EW'(1) >= w_pos) o_cmd[k] = pidl_pkg::CELL_FROM_NEXT;
                    end
                end
            end
            pidl_pkg::OP_EDIT: begin
                if (!(w_pos_zero || w_pos > w_cnt)) begin
                    w_status = pidl_pkg::ST_DONE;
                    for (int k = 0; k < DEPTH; k++) begin
                        if (EW'(k) + EW'(1) == w_pos) o_cmd[k] = pidl_pkg::CELL_LOAD;
                    end
                end
            end
            default: begin
                w_status = pidl_pkg::ST_RANGE;
            end
        endcase
        // drop all changes unless the item is taken
        if (!i_fire) begin
            n_count = r_count;
            for (int k = 0; k < DEPTH; k++) begin
                o_cmd[k] = pidl_pkg::CELL_HOLD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_result.status     = w_status;
    assign o_result.fill_count = pidl_pkg::FILL_BITS'(n_count);
    assign o_result.list_full  = (EW'(n_count) == w_depth);

endmodule

// ===== rtl/pidl_checker.sv =====
`timescale 1ns / 1ps
module pidl_checker #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input pidl_pkg::t_in  i_in,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input pidl_pkg::t_out o_out
);

    // Fill count never passes the depth
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (DEPTH < 16) |-> o_out.fill_count <= pidl_pkg::FILL_BITS'(DEPTH))
        else $error("fill count above depth");

    // Full flag agrees with the fill count
    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.list_full |-> o_out.fill_count == pidl_pkg::FILL_BITS'(DEPTH))
        else $error("full flag without full count");

    // A full status is only reported on a full list
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.status == pidl_pkg::ST_FULL |-> o_out.list_full)
        else $error("full status on a list that is not full");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result dropped or changed under stall");

    // An offered item holds until it is taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in))
        else $error("input item dropped or changed while waiting");

endmodule

bind positional_insert_delete_list_core pidl_checker #(
    .DEPTH (DEPTH)
) u_pidl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in        (i_in),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);
